@@ rtl/wbcjr_pkg.sv @@
// shared types and codes for the windowed bcjr branch posterior block
// no dependencies; used by every module of the block
`default_nettype none

package wbcjr_pkg;

   // input item modes
   typedef enum logic [2:0] {
      MODE_PRED   = 3'd0,
      MODE_SUCC   = 3'd1,
      MODE_MAP    = 3'd2,
      MODE_ALPHA  = 3'd3,
      MODE_BETA   = 3'd4,
      MODE_METRIC = 3'd5
   } mode_type;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT,
      ST_COL,
      ST_ACC_RD,
      ST_ACC_LD,
      ST_MAC_RD,
      ST_MAC_MUL,
      ST_MAC_ADD,
      ST_ACC_ST,
      ST_NORM_RD,
      ST_NORM_DIV,
      ST_NORM_WAIT,
      ST_NORM_WR,
      ST_OUT_RD,
      ST_OUT_MUL1,
      ST_OUT_MUL2,
      ST_OUT_LD
   } state_type;

   // fixed field widths
   localparam int STATE_VAL_W = 4;
   localparam int MAP_VAL_W   = 5;
   localparam int PROB_W      = 16;
   localparam int STEP_W      = 16;
   localparam int BRANCH_W    = 5;

   // controller to datapath commands
   typedef struct packed {
      logic clear_fault;
      logic clear_sum;
      logic acc_init;
      logic rd_prev;
      logic mul_en;
      logic acc_add;
      logic store_u;
      logic div_start;
      logic norm_wr;
      logic dir_beta;
      logic out_phase;
      logic out_mul1;
      logic out_mul2;
      logic out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic start_run;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/windowed_bcjr_branch_posterior.sv @@
// top level of the windowed bcjr branch posterior block
// uses wbcjr_pkg, instantiates wbcjr_ctrl and wbcjr_dp
`default_nettype none

// Table loads, start-column loads and branch metrics are taken one item per
// cycle while the block is idle. The marked last metric of a step, once
// 2*WINDOW+1 steps are complete, starts a run for step k = step - WINDOW that
// holds off new items while it runs. Its length is set by the one shared 16x16
// multiplier that performs every forward and backward branch term in turn, and
// by the bit-serial divider that normalises each column value in turn.
// The posteriors of step k then leave one by one through an output register
// when the result side is ready; the block takes input again while the last
// result of a step waits there. Probabilities are unsigned Q0.16; a zero column
// sum gives a zero column and raises divide_fault on every result of that step.
module windowed_bcjr_branch_posterior #(
   parameter int STATES   = 16,
   parameter int BRANCHES = 2,
   parameter int WINDOW   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic [15:0] req_value,
   input  wire logic        req_last_in_step,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_posterior,
   output logic [4:0]       rsp_branch_number,
   output logic [15:0]      rsp_time_step,
   output logic             rsp_last_of_step,
   output logic             rsp_divide_fault
);

   localparam int SB  = STATES * BRANCHES;
   localparam int SIW = $clog2(STATES);
   localparam int BIW = $clog2(BRANCHES);
   localparam int NW  = $clog2(SB);
   localparam int WCW = $clog2(WINDOW + 1);

   wbcjr_pkg::cmd_type  cmd;
   wbcjr_pkg::stat_type stat;
   logic            idle;
   logic [WCW-1:0]  w_idx;
   logic [SIW-1:0]  s_idx;
   logic [BIW-1:0]  b_idx;
   logic [NW-1:0]   n_idx;

   // items are taken only while the sequencer is idle
   assign req_ready = idle;

   wbcjr_ctrl #(
      .STATES   (STATES),
      .BRANCHES (BRANCHES),
      .WINDOW   (WINDOW)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd),
      .idle  (idle),
      .w_idx (w_idx),
      .s_idx (s_idx),
      .b_idx (b_idx),
      .n_idx (n_idx)
   );

   wbcjr_dp #(
      .STATES   (STATES),
      .BRANCHES (BRANCHES),
      .WINDOW   (WINDOW)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .w_idx             (w_idx),
      .s_idx             (s_idx),
      .b_idx             (b_idx),
      .n_idx             (n_idx),
      .accept            (req_valid && idle),
      .req_mode          (req_mode),
      .req_entry_index   (req_entry_index),
      .req_value         (req_value),
      .req_last_in_step  (req_last_in_step),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_posterior     (rsp_posterior),
      .rsp_branch_number (rsp_branch_number),
      .rsp_time_step     (rsp_time_step),
      .rsp_last_of_step  (rsp_last_of_step),
      .rsp_divide_fault  (rsp_divide_fault)
   );

endmodule

`default_nettype wire

@@ rtl/wbcjr_div.sv @@
// bit-serial restoring divider for column normalisation, one quotient bit a cycle
// uses wbcjr_pkg for the probability width
`default_nettype none

module wbcjr_div #(
   parameter int SUMW = 38
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [SUMW-1:0]                num,
   input  wire logic [SUMW-1:0]                den,
   output logic                                done,
   output logic [wbcjr_pkg::PROB_W-1:0]        quo
);

   localparam int QW = wbcjr_pkg::PROB_W + 1;
   localparam int CNTW = $clog2(QW + 1);

   logic [SUMW:0]   rem_ff, rem_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            first_ff, first_in;
   logic            done_ff, done_in;
   logic [SUMW:0]   trial;
   logic            bit_ok;

   // one restoring step: the first step uses the numerator unshifted
   always_comb begin
      trial  = first_ff ? rem_ff : {rem_ff[SUMW-1:0], 1'b0};
      bit_ok = trial >= {1'b0, den};
      rem_in   = rem_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = {1'b0, num};
         cnt_in   = CNTW'(QW);
         first_in = 1'b1;
      end else if (cnt_ff != '0) begin
         rem_in   = bit_ok ? trial - {1'b0, den} : trial;
         q_in     = {q_ff[QW-2:0], bit_ok};
         cnt_in   = cnt_ff - CNTW'(1);
         first_in = 1'b0;
         done_in  = cnt_ff == CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      first_ff <= first_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // an integer part of one saturates
   assign done = done_ff;
   assign quo  = q_ff[QW-1] ? '1 : q_ff[QW-2:0];

endmodule

`default_nettype wire

@@ rtl/wbcjr_ctrl.sv @@
// sequencer for loads, the windowed recursions and the posterior output
// uses wbcjr_pkg for states, commands and status
`default_nettype none

module wbcjr_ctrl #(
   parameter int STATES   = 16,
   parameter int BRANCHES = 2,
   parameter int WINDOW   = 8,
   localparam int SB   = STATES * BRANCHES,
   localparam int SIW  = $clog2(STATES),
   localparam int BIW  = $clog2(BRANCHES),
   localparam int NW   = $clog2(SB),
   localparam int WCW  = $clog2(WINDOW + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wbcjr_pkg::stat_type  stat,
   output wbcjr_pkg::cmd_type        cmd,
   output logic                      idle,
   output logic [WCW-1:0]            w_idx,
   output logic [SIW-1:0]            s_idx,
   output logic [BIW-1:0]            b_idx,
   output logic [NW-1:0]             n_idx
);

   wbcjr_pkg::state_type state_ff, state_in;
   logic [WCW-1:0] w_ff, w_in;
   logic [SIW-1:0] s_ff, s_in;
   logic [BIW-1:0] b_ff, b_in;
   logic [NW-1:0]  n_ff, n_in;
   logic           dir_ff, dir_in;
   logic           s_last, b_last;

   assign s_last = s_ff == SIW'(STATES - 1);
   assign b_last = b_ff == BIW'(BRANCHES - 1);

   // next state and counters
   always_comb begin
      state_in = state_ff;
      w_in     = w_ff;
      s_in     = s_ff;
      b_in     = b_ff;
      n_in     = n_ff;
      dir_in   = dir_ff;
      unique case (state_ff)
         wbcjr_pkg::ST_IDLE: begin
            if (stat.start_run) state_in = wbcjr_pkg::ST_INIT;
         end
         wbcjr_pkg::ST_INIT: begin
            w_in     = WCW'(1);
            dir_in   = 1'b0;
            state_in = wbcjr_pkg::ST_COL;
         end
         wbcjr_pkg::ST_COL: begin
            s_in     = '0;
            state_in = wbcjr_pkg::ST_ACC_RD;
         end
         wbcjr_pkg::ST_ACC_RD: state_in = wbcjr_pkg::ST_ACC_LD;
         wbcjr_pkg::ST_ACC_LD: begin
            b_in     = '0;
            state_in = wbcjr_pkg::ST_MAC_RD;
         end
         wbcjr_pkg::ST_MAC_RD:  state_in = wbcjr_pkg::ST_MAC_MUL;
         wbcjr_pkg::ST_MAC_MUL: state_in = wbcjr_pkg::ST_MAC_ADD;
         wbcjr_pkg::ST_MAC_ADD: begin
            if (b_last) begin
               state_in = wbcjr_pkg::ST_ACC_ST;
            end else begin
               b_in     = b_ff + BIW'(1);
               state_in = wbcjr_pkg::ST_MAC_RD;
            end
         end
         wbcjr_pkg::ST_ACC_ST: begin
            if (s_last) begin
               s_in     = '0;
               state_in = wbcjr_pkg::ST_NORM_RD;
            end else begin
               s_in     = s_ff + SIW'(1);
               state_in = wbcjr_pkg::ST_ACC_RD;
            end
         end
         wbcjr_pkg::ST_NORM_RD:  state_in = wbcjr_pkg::ST_NORM_DIV;
         wbcjr_pkg::ST_NORM_DIV: state_in = wbcjr_pkg::ST_NORM_WAIT;
         wbcjr_pkg::ST_NORM_WAIT: begin
            if (stat.div_done) state_in = wbcjr_pkg::ST_NORM_WR;
         end
         wbcjr_pkg::ST_NORM_WR: begin
            if (!s_last) begin
               s_in     = s_ff + SIW'(1);
               state_in = wbcjr_pkg::ST_NORM_RD;
            end else if (!dir_ff) begin
               dir_in   = 1'b1;
               state_in = wbcjr_pkg::ST_COL;
            end else if (w_ff == WCW'(WINDOW)) begin
               s_in     = '0;
               b_in     = '0;
               n_in     = '0;
               state_in = wbcjr_pkg::ST_OUT_RD;
            end else begin
               w_in     = w_ff + WCW'(1);
               dir_in   = 1'b0;
               state_in = wbcjr_pkg::ST_COL;
            end
         end
         wbcjr_pkg::ST_OUT_RD:   state_in = wbcjr_pkg::ST_OUT_MUL1;
         wbcjr_pkg::ST_OUT_MUL1: state_in = wbcjr_pkg::ST_OUT_MUL2;
         wbcjr_pkg::ST_OUT_MUL2: state_in = wbcjr_pkg::ST_OUT_LD;
         wbcjr_pkg::ST_OUT_LD: begin
            if (stat.out_free) begin
               if (n_ff == NW'(SB - 1)) begin
                  state_in = wbcjr_pkg::ST_IDLE;
               end else begin
                  n_in = n_ff + NW'(1);
                  if (b_last) begin
                     b_in = '0;
                     s_in = s_ff + SIW'(1);
                  end else begin
                     b_in = b_ff + BIW'(1);
                  end
                  state_in = wbcjr_pkg::ST_OUT_RD;
               end
            end
         end
         default: state_in = wbcjr_pkg::ST_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      cmd           = '0;
      cmd.dir_beta  = dir_ff;
      unique case (state_ff)
         wbcjr_pkg::ST_INIT:     cmd.clear_fault = 1'b1;
         wbcjr_pkg::ST_COL:      cmd.clear_sum   = 1'b1;
         wbcjr_pkg::ST_ACC_LD:   cmd.acc_init    = 1'b1;
         wbcjr_pkg::ST_MAC_RD:   cmd.rd_prev     = 1'b1;
         wbcjr_pkg::ST_MAC_MUL:  cmd.mul_en      = 1'b1;
         wbcjr_pkg::ST_MAC_ADD:  cmd.acc_add     = 1'b1;
         wbcjr_pkg::ST_ACC_ST:   cmd.store_u     = 1'b1;
         wbcjr_pkg::ST_NORM_DIV: cmd.div_start   = 1'b1;
         wbcjr_pkg::ST_NORM_WR:  cmd.norm_wr     = 1'b1;
         wbcjr_pkg::ST_OUT_RD:   cmd.out_phase   = 1'b1;
         wbcjr_pkg::ST_OUT_MUL1: begin
            cmd.out_phase = 1'b1;
            cmd.out_mul1  = 1'b1;
         end
         wbcjr_pkg::ST_OUT_MUL2: begin
            cmd.out_phase = 1'b1;
            cmd.out_mul2  = 1'b1;
         end
         wbcjr_pkg::ST_OUT_LD: begin
            cmd.out_phase = 1'b1;
            cmd.out_load  = 1'b1;
         end
         default: cmd.dir_beta = dir_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wbcjr_pkg::ST_IDLE;
         w_ff     <= '0;
         s_ff     <= '0;
         b_ff     <= '0;
         n_ff     <= '0;
         dir_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         w_ff     <= w_in;
         s_ff     <= s_in;
         b_ff     <= b_in;
         n_ff     <= n_in;
         dir_ff   <= dir_in;
      end
   end

   assign idle  = state_ff == wbcjr_pkg::ST_IDLE;
   assign w_idx = w_ff;
   assign s_idx = s_ff;
   assign b_idx = b_ff;
   assign n_idx = n_ff;

endmodule

`default_nettype wire

@@ rtl/wbcjr_dp.sv @@
// datapath: trellis tables, start and work columns, metric window, mac and output register
// uses wbcjr_pkg and instantiates wbcjr_div
`default_nettype none

module wbcjr_dp #(
   parameter int STATES   = 16,
   parameter int BRANCHES = 2,
   parameter int WINDOW   = 8,
   localparam int SB    = STATES * BRANCHES,
   localparam int CELLS = STATES * (WINDOW + 1),
   localparam int SLOTS = 2 * WINDOW + 2,
   localparam int SIW   = $clog2(STATES),
   localparam int BIW   = $clog2(BRANCHES),
   localparam int NW    = $clog2(SB),
   localparam int WCW   = $clog2(WINDOW + 1),
   localparam int CW    = $clog2(CELLS),
   localparam int LW    = $clog2(SLOTS),
   localparam int MW    = $clog2(SLOTS * SB)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire wbcjr_pkg::cmd_type                  cmd,
   output wbcjr_pkg::stat_type                      stat,
   input  wire logic [WCW-1:0]                      w_idx,
   input  wire logic [SIW-1:0]                      s_idx,
   input  wire logic [BIW-1:0]                      b_idx,
   input  wire logic [NW-1:0]                       n_idx,
   input  wire logic                                accept,
   input  wire logic [2:0]                          req_mode,
   input  wire logic [7:0]                          req_entry_index,
   input  wire logic [15:0]                         req_value,
   input  wire logic                                req_last_in_step,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [15:0]                              rsp_posterior,
   output logic [4:0]                               rsp_branch_number,
   output logic [15:0]                              rsp_time_step,
   output logic                                     rsp_last_of_step,
   output logic                                     rsp_divide_fault
);

   localparam int PW   = wbcjr_pkg::PROB_W;
   localparam int SVW  = wbcjr_pkg::STATE_VAL_W;
   localparam int MVW  = wbcjr_pkg::MAP_VAL_W;
   localparam int UW   = 2 * PW + $clog2(BRANCHES + 1);
   localparam int SUMW = UW + $clog2(STATES);

   // trellis tables
   logic [SVW-1:0] pred_ff [SB];
   logic [SVW-1:0] succ_ff [SB];
   logic [MVW-1:0] map_ff  [SB];

   // start columns with valid bits, work columns, metric window, column sums
   logic [PW-1:0]  a_st_mem [CELLS];
   logic [PW-1:0]  b_st_mem [CELLS];
   logic [CELLS-1:0] a_vld_ff, b_vld_ff;
   logic [PW-1:0]  a_wk_mem [CELLS];
   logic [PW-1:0]  b_wk_mem [CELLS];
   logic [PW-1:0]  met_mem  [SLOTS * SB];
   logic [UW-1:0]  u_mem    [STATES];

   logic [PW-1:0]  a_st_rd_ff, b_st_rd_ff, a_wk_rd_ff, b_wk_rd_ff, met_rd_ff;
   logic           a_st_v_ff, b_st_v_ff, oor_ff;
   logic [UW-1:0]  u_rd_ff;

   logic [wbcjr_pkg::STEP_W-1:0] step_ff, k_ff;
   logic [NW-1:0]  fill_ff;
   logic [LW-1:0]  slot_ff, run_slot_ff;

   logic [UW-1:0]   acc_ff;
   logic [SUMW-1:0] sum_ff;
   logic [2*PW-1:0] prod_ff, ab_ff;
   logic [3*PW-1:0] pp_ff;
   logic            fault_ff;

   logic            rsp_valid_ff;
   logic [15:0]     rsp_post_ff, rsp_time_ff;
   logic [4:0]      rsp_branch_ff;
   logic            rsp_last_ff, rsp_fault_ff;

   logic            div_done;
   logic [PW-1:0]   div_quo;

   // address generation
   logic [NW-1:0]  tbl_idx, mac_n, met_n;
   logic [SVW-1:0] t_state;
   logic [MVW-1:0] map_val;
   logic [WCW-1:0] col_cur, col_prev;
   logic [CW-1:0]  cur_cell, prev_cell, st_addr, aw_addr, bw_addr;
   logic [LW:0]    slot_d, slot_x;
   logic [LW-1:0]  slot_sel;
   logic [MW-1:0]  met_raddr, met_waddr;
   logic           oor_in, from_start;
   logic [PW-1:0]  st_val, prev_val, a_st_val, b_st_val;
   logic           is_metric, run_now;

   always_comb begin
      tbl_idx  = NW'(b_idx) * NW'(STATES) + NW'(s_idx);
      mac_n    = NW'(s_idx) * NW'(BRANCHES) + NW'(b_idx);
      map_val  = map_ff[mac_n];
      t_state  = (!cmd.dir_beta && !cmd.out_phase) ? pred_ff[tbl_idx] : succ_ff[tbl_idx];
      col_cur  = cmd.dir_beta ? WCW'(WINDOW) - w_idx : w_idx;
      col_prev = cmd.dir_beta ? WCW'(WINDOW) - w_idx + WCW'(1) : w_idx - WCW'(1);
      cur_cell  = CW'(col_cur) * CW'(STATES) + CW'(s_idx);
      prev_cell = CW'(col_prev) * CW'(STATES) + CW'(t_state);
      st_addr   = cmd.rd_prev ? prev_cell : cur_cell;
      aw_addr   = cmd.out_phase ? CW'(WINDOW * STATES) + CW'(s_idx) : prev_cell;
      bw_addr   = cmd.out_phase ? CW'(t_state) : prev_cell;
      // out of range table entries contribute zero
      oor_in = (32'(t_state) >= STATES)
             || (!cmd.dir_beta && !cmd.out_phase && (32'(map_val) >= SB));
      // slot of the step in use, counted back from the newest step
      if (cmd.out_phase)     slot_d = (LW+1)'(WINDOW);
      else if (cmd.dir_beta) slot_d = (LW+1)'(w_idx) - (LW+1)'(1);
      else                   slot_d = (LW+1)'(2 * WINDOW + 1) - (LW+1)'(w_idx);
      slot_x = ({1'b0, run_slot_ff} >= slot_d) ? {1'b0, run_slot_ff} - slot_d
             : {1'b0, run_slot_ff} + (LW+1)'(SLOTS) - slot_d;
      slot_sel = slot_x[LW-1:0];
      if (cmd.out_phase)     met_n = n_idx;
      else if (cmd.dir_beta) met_n = mac_n;
      else                   met_n = NW'(map_val);
      met_raddr = MW'(slot_sel) * MW'(SB) + MW'(met_n);
      met_waddr = MW'(slot_ff) * MW'(SB) + MW'(fill_ff);
      a_st_val  = a_st_v_ff ? a_st_rd_ff : '0;
      b_st_val  = b_st_v_ff ? b_st_rd_ff : '0;
      st_val    = cmd.dir_beta ? b_st_val : a_st_val;
      from_start = w_idx == WCW'(1);
      prev_val  = from_start ? st_val : (cmd.dir_beta ? b_wk_rd_ff : a_wk_rd_ff);
      is_metric = req_mode == wbcjr_pkg::MODE_METRIC;
      run_now   = accept && is_metric && req_last_in_step
                && (step_ff >= wbcjr_pkg::STEP_W'(2 * WINDOW + 1));
   end

   // table loads
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SB; i++) begin
            pred_ff[i] <= '0;
            succ_ff[i] <= '0;
            map_ff[i]  <= '0;
         end
      end else if (accept && (32'(req_entry_index) < SB)) begin
         case (wbcjr_pkg::mode_type'(req_mode))
            wbcjr_pkg::MODE_PRED: pred_ff[NW'(req_entry_index)] <= req_value[SVW-1:0];
            wbcjr_pkg::MODE_SUCC: succ_ff[NW'(req_entry_index)] <= req_value[SVW-1:0];
            wbcjr_pkg::MODE_MAP:  map_ff[NW'(req_entry_index)]  <= req_value[MVW-1:0];
            default: ;
         endcase
      end
   end

   // start column valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
         b_vld_ff <= '0;
      end else if (accept && (32'(req_entry_index) < CELLS)) begin
         if (req_mode == wbcjr_pkg::MODE_ALPHA) a_vld_ff[CW'(req_entry_index)] <= 1'b1;
         if (req_mode == wbcjr_pkg::MODE_BETA)  b_vld_ff[CW'(req_entry_index)] <= 1'b1;
      end
   end

   // start column memories
   always_ff @(posedge clock) begin
      if (accept && (32'(req_entry_index) < CELLS)) begin
         if (req_mode == wbcjr_pkg::MODE_ALPHA) a_st_mem[CW'(req_entry_index)] <= req_value;
         if (req_mode == wbcjr_pkg::MODE_BETA)  b_st_mem[CW'(req_entry_index)] <= req_value;
      end
      a_st_rd_ff <= a_st_mem[st_addr];
      b_st_rd_ff <= b_st_mem[st_addr];
      a_st_v_ff  <= a_vld_ff[st_addr];
      b_st_v_ff  <= b_vld_ff[st_addr];
   end

   // work column memories
   always_ff @(posedge clock) begin
      if (cmd.norm_wr) begin
         if (cmd.dir_beta) b_wk_mem[cur_cell] <= (sum_ff == '0) ? '0 : div_quo;
         else              a_wk_mem[cur_cell] <= (sum_ff == '0) ? '0 : div_quo;
      end
      a_wk_rd_ff <= a_wk_mem[aw_addr];
      b_wk_rd_ff <= b_wk_mem[bw_addr];
      oor_ff     <= oor_in;
   end

   // metric window memory
   always_ff @(posedge clock) begin
      if (accept && is_metric) met_mem[met_waddr] <= req_value;
      met_rd_ff <= met_mem[met_raddr];
   end

   // unnormalised column store
   always_ff @(posedge clock) begin
      if (cmd.store_u) u_mem[s_idx] <= acc_ff;
      u_rd_ff <= u_mem[s_idx];
   end

   // step counting and window slot tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= '0;
         fill_ff     <= '0;
         slot_ff     <= '0;
         run_slot_ff <= '0;
         k_ff        <= '0;
      end else if (accept && is_metric) begin
         if (req_last_in_step) begin
            fill_ff <= '0;
            step_ff <= step_ff + wbcjr_pkg::STEP_W'(1);
            if (step_ff == '1 || slot_ff == LW'(SLOTS - 1)) slot_ff <= '0;
            else slot_ff <= slot_ff + LW'(1);
            if (run_now) begin
               run_slot_ff <= slot_ff;
               k_ff        <= step_ff - wbcjr_pkg::STEP_W'(WINDOW);
            end
         end else if (fill_ff != NW'(SB - 1)) begin
            fill_ff <= fill_ff + NW'(1);
         end
      end
   end

   // multiply-accumulate and posterior products
   always_ff @(posedge clock) begin
      if (cmd.acc_init) acc_ff <= UW'({st_val, {PW{1'b0}}});
      else if (cmd.acc_add) acc_ff <= acc_ff + UW'(prod_ff);
      if (cmd.clear_sum) sum_ff <= '0;
      else if (cmd.store_u) sum_ff <= sum_ff + SUMW'(acc_ff);
      if (cmd.mul_en) prod_ff <= oor_ff ? '0 : prev_val * met_rd_ff;
      if (cmd.out_mul1) ab_ff <= oor_ff ? '0 : a_wk_rd_ff * b_wk_rd_ff;
      if (cmd.out_mul2) pp_ff <= ab_ff * met_rd_ff;
   end

   // fault flag for the step
   always_ff @(posedge clock) begin
      if (reset) fault_ff <= 1'b0;
      else if (cmd.clear_fault) fault_ff <= 1'b0;
      else if (cmd.div_start && sum_ff == '0) fault_ff <= 1'b1;
   end

   wbcjr_div #(
      .SUMW (SUMW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (SUMW'(u_rd_ff)),
      .den   (sum_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load && stat.out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load && stat.out_free) begin
         rsp_post_ff   <= pp_ff[3*PW-1:2*PW];
         rsp_branch_ff <= 5'(n_idx);
         rsp_time_ff   <= k_ff;
         rsp_last_ff   <= n_idx == NW'(SB - 1);
         rsp_fault_ff  <= fault_ff;
      end
   end

   assign stat.start_run = run_now;
   assign stat.div_done  = div_done;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_posterior     = rsp_post_ff;
   assign rsp_branch_number = rsp_branch_ff;
   assign rsp_time_step     = rsp_time_ff;
   assign rsp_last_of_step  = rsp_last_ff;
   assign rsp_divide_fault  = rsp_fault_ff;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench for the windowed bcjr branch posterior block
// depends on rtl/wbcjr_pkg.sv and rtl/windowed_bcjr_branch_posterior.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STATES   = 16;
   localparam int BRANCHES = 2;
   localparam int WINDOW   = 8;
   localparam int SB       = STATES * BRANCHES;
   localparam int CELLS    = STATES * (WINDOW + 1);
   localparam int SLOTS    = 2 * WINDOW + 2;
   localparam int RUN_GAP  = 7500;
   localparam int MODE_UNUSED_LO = 6;
   localparam int MODE_UNUSED_HI = 7;

   typedef struct packed {
      logic [15:0] posterior;
      logic [4:0]  branch_number;
      logic [15:0] time_step;
      logic        last_of_step;
      logic        divide_fault;
   } posterior_type;

   // trellis state mirror and queue of expected posteriors
   class posterior_board;
      bit [15:0] alpha_seed[CELLS];
      bit [15:0] beta_seed[CELLS];
      bit [15:0] alpha_col[CELLS];
      bit [15:0] beta_col[CELLS];
      bit [3:0]  pred_tab[SB];
      bit [3:0]  succ_tab[SB];
      bit [4:0]  map_tab[SB];
      bit [15:0] metrics[SLOTS * SB];
      bit [15:0] steps_done;
      int        fill;
      posterior_type awaited[$];
      int        errors;

      function longint unsigned metric(int unsigned t, int unsigned n);
         return metrics[(t % SLOTS) * SB + n];
      endfunction

      // normalise one column to sum one, zero column on zero sum
      function void normalise(input longint unsigned u[STATES], input int base,
                              input bit to_alpha, inout bit fault);
         longint unsigned total, q;
         total = 0;
         foreach (u[s]) total += u[s];
         for (int s = 0; s < STATES; s++) begin
            q = 0;
            if (total != 0) begin
               q = (u[s] << 16) / total;
               if (q > 65535) q = 65535;
            end
            if (to_alpha) alpha_col[base + s] = q[15:0];
            else beta_col[base + s] = q[15:0];
         end
         if (total == 0) fault = 1;
      endfunction

      // windowed forward and backward passes, then the step's posteriors
      function void predict_step(int unsigned k);
         longint unsigned ua[STATES], ub[STATES], av, bv, p;
         int unsigned ta, tb;
         bit fault;
         posterior_type r;
         fault = 0;
         alpha_col = alpha_seed;
         beta_col = beta_seed;
         for (int w = 1; w <= WINDOW; w++) begin
            ta = k - WINDOW - 1 + w;
            tb = k + WINDOW - w + 1;
            for (int s = 0; s < STATES; s++) begin
               ua[s] = longint'(alpha_seed[w * STATES + s]) << 16;
               ub[s] = longint'(beta_seed[(WINDOW - w) * STATES + s]) << 16;
               for (int b = 0; b < BRANCHES; b++) begin
                  av = alpha_col[(w - 1) * STATES + pred_tab[s + STATES * b]];
                  bv = beta_col[(WINDOW - w + 1) * STATES + succ_tab[s + STATES * b]];
                  ua[s] += av * metric(ta, map_tab[s * BRANCHES + b]);
                  ub[s] += bv * metric(tb, s * BRANCHES + b);
               end
            end
            normalise(ua, w * STATES, 1, fault);
            normalise(ub, (WINDOW - w) * STATES, 0, fault);
         end
         for (int n = 0; n < SB; n++) begin
            av = alpha_col[WINDOW * STATES + n / BRANCHES];
            bv = beta_col[succ_tab[n / BRANCHES + STATES * (n % BRANCHES)]];
            p = av * bv * metric(k, n);
            r.posterior = p[47:32];
            r.branch_number = n[4:0];
            r.time_step = k[15:0];
            r.last_of_step = (n == SB - 1);
            r.divide_fault = fault;
            awaited.push_back(r);
         end
      endfunction

      // note one accepted input item
      function void note_item(bit [2:0] mode, bit [7:0] idx, bit [15:0] val, bit mark);
         int unsigned s;
         case (mode)
            wbcjr_pkg::MODE_PRED:  if (idx < SB) pred_tab[idx] = val[3:0];
            wbcjr_pkg::MODE_SUCC:  if (idx < SB) succ_tab[idx] = val[3:0];
            wbcjr_pkg::MODE_MAP:   if (idx < SB) map_tab[idx] = val[4:0];
            wbcjr_pkg::MODE_ALPHA: if (idx < CELLS) alpha_seed[idx] = val;
            wbcjr_pkg::MODE_BETA:  if (idx < CELLS) beta_seed[idx] = val;
            wbcjr_pkg::MODE_METRIC: begin
               s = steps_done;
               metrics[(s % SLOTS) * SB + fill] = val;
               if (mark) begin
                  fill = 0;
                  if (s >= 2 * WINDOW + 1) predict_step(s - WINDOW);
                  steps_done = 16'(s + 1);
               end else if (fill < SB - 1) begin
                  fill++;
               end
            end
            default: ;
         endcase
      endfunction

      // compare one accepted posterior with the oldest expectation
      function void check_result(posterior_type got);
         posterior_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected posterior %p", $realtime, got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.posterior != want.posterior) begin
            $display("%0t: posterior exp %0d got %0d", $realtime,
                     want.posterior, got.posterior);
            errors++;
         end
         if (got.branch_number != want.branch_number) begin
            $display("%0t: branch_number exp %0d got %0d", $realtime,
                     want.branch_number, got.branch_number);
            errors++;
         end
         if (got.time_step != want.time_step) begin
            $display("%0t: time_step exp %0d got %0d", $realtime,
                     want.time_step, got.time_step);
            errors++;
         end
         if (got.last_of_step != want.last_of_step) begin
            $display("%0t: last_of_step exp %0d got %0d", $realtime,
                     want.last_of_step, got.last_of_step);
            errors++;
         end
         if (got.divide_fault != want.divide_fault) begin
            $display("%0t: divide_fault exp %0d got %0d", $realtime,
                     want.divide_fault, got.divide_fault);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_mode;
   logic [7:0]  req_entry_index;
   logic [15:0] req_value;
   logic        req_last_in_step;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_posterior;
   logic [4:0]  rsp_branch_number;
   logic [15:0] rsp_time_step;
   logic        rsp_last_of_step;
   logic        rsp_divide_fault;

   posterior_board board;
   bit             calm;

   windowed_bcjr_branch_posterior u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_entry_index(req_entry_index), .req_value(req_value),
      .req_last_in_step(req_last_in_step),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_posterior(rsp_posterior),
      .rsp_branch_number(rsp_branch_number), .rsp_time_step(rsp_time_step),
      .rsp_last_of_step(rsp_last_of_step), .rsp_divide_fault(rsp_divide_fault)
   );

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // send one item, holding it until accepted
   task automatic send_item(bit [2:0] mode, bit [7:0] idx, bit [15:0] val, bit mark);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_entry_index <= idx;
      req_value <= val;
      req_last_in_step <= mark;
      do @(posedge clock); while (!req_ready);
      board.note_item(mode, idx, val, mark);
   endtask

   function automatic bit [15:0] rand_prob();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   // one full step of metrics, marked on the last
   task automatic send_full_step();
      for (int n = 0; n < SB; n++)
         send_item(wbcjr_pkg::MODE_METRIC, 8'($urandom()), rand_prob(), n == SB - 1);
   endtask

   // idle the input and wait for every expected posterior
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (RUN_GAP) @(posedge clock);
   endtask

   // result side with random stalls
   initial begin
      int stall;
      posterior_type got;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = {rsp_posterior, rsp_branch_number, rsp_time_step,
                rsp_last_of_step, rsp_divide_fault};
         board.check_result(got);
      end
   end

   // stimulus
   initial begin
      int nmet;
      board = new();
      calm = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = wbcjr_pkg::MODE_PRED;
      req_entry_index = '0;
      req_value = '0;
      req_last_in_step = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // trellis tables
      for (int i = 0; i < SB; i++) begin
         send_item(wbcjr_pkg::MODE_PRED, 8'(i), 16'($urandom()), 1'b0);
         send_item(wbcjr_pkg::MODE_SUCC, 8'(i), 16'($urandom()), 1'b0);
         send_item(wbcjr_pkg::MODE_MAP, 8'(i), 16'($urandom()), 1'b0);
      end
      // start columns: first column in full, the rest sparse
      for (int i = 0; i < STATES; i++) begin
         send_item(wbcjr_pkg::MODE_ALPHA, 8'(i), rand_prob(), 1'b0);
         send_item(wbcjr_pkg::MODE_BETA, 8'(i), rand_prob(), 1'b0);
      end
      for (int i = 0; i < 12; i++) begin
         send_item(wbcjr_pkg::MODE_ALPHA, 8'($urandom_range(STATES, CELLS - 1)),
                   16'($urandom()), 1'b0);
         send_item(wbcjr_pkg::MODE_BETA, 8'($urandom_range(STATES, CELLS - 1)),
                   16'($urandom()), 1'b0);
      end

      // directed corner items: out of range loads, unused modes
      send_item(wbcjr_pkg::MODE_ALPHA, 8'd255, 16'hFFFF, 1'b1);
      send_item(wbcjr_pkg::MODE_BETA, 8'(CELLS), 16'hFFFF, 1'b1);
      send_item(wbcjr_pkg::MODE_PRED, 8'd200, 16'hFFFF, 1'b1);
      send_item(wbcjr_pkg::MODE_MAP, 8'(SB), 16'hFFFF, 1'b0);
      send_item(3'(MODE_UNUSED_LO), 8'hFF, 16'hFFFF, 1'b1);
      send_item(3'(MODE_UNUSED_HI), 8'hAA, 16'h5555, 1'b1);

      // fill the metric window; the first step overfills, marked only on its last item
      calm = 1;
      for (int i = 0; i < SB + 2; i++)
         send_item(wbcjr_pkg::MODE_METRIC, 8'd0, 16'hFFFF, i == SB + 1);
      calm = 0;
      for (int t = 1; t < SLOTS; t++) send_full_step();

      // hold off until the first run has been delivered
      drain_results();

      // random steps, mostly short with the odd full step and some loads
      for (int t = 0; t < 25; t++) begin
         calm = (t % 10) >= 8;
         repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 5))
               0: send_item(wbcjr_pkg::MODE_PRED, 8'($urandom_range(0, SB)),
                            16'($urandom()), 1'($urandom()));
               1: send_item(wbcjr_pkg::MODE_SUCC, 8'($urandom_range(0, SB)),
                            16'($urandom()), 1'($urandom()));
               2: send_item(wbcjr_pkg::MODE_MAP, 8'($urandom_range(0, SB)),
                            16'($urandom()), 1'($urandom()));
               3: send_item(wbcjr_pkg::MODE_ALPHA, 8'($urandom()), rand_prob(),
                            1'($urandom()));
               4: send_item(wbcjr_pkg::MODE_BETA, 8'($urandom()), rand_prob(),
                            1'($urandom()));
               default: send_item(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)),
                                  8'($urandom()), 16'($urandom()), 1'($urandom()));
            endcase
         end
         if ($urandom_range(0, 7) == 0) begin
            send_full_step();
         end else begin
            nmet = $urandom_range(1, 4);
            for (int n = 0; n < nmet; n++)
               send_item(wbcjr_pkg::MODE_METRIC, 8'($urandom()), rand_prob(),
                         n == nmet - 1);
         end
      end

      drain_results();
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #30_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule

`default_nettype wire
